// ----- rtl/core/assert_macros.svh -----
// Assertion macros shared by the core RTL.
// Each macro expands to one labeled concurrent assertion that reports by $error.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Antecedent true implies consequent true in the same cycle.
`define ASSERT_IMP(lbl, ck, rn, a, c) \
  lbl: assert property (@(posedge ck) disable iff (!rn) (a) |-> (c)) \
    else $error("implication check failed");

// Condition holds at every clock edge outside reset.
`define ASSERT_ALWAYS(lbl, ck, rn, c) \
  lbl: assert property (@(posedge ck) disable iff (!rn) (c)) \
    else $error("invariant check failed");

`endif

// ----- rtl/core/oaht_pkg.sv -----
// Package for the open-addressed hash table: widths, codes, constants and
// the command/status structs between controller and datapath. No dependencies.
`timescale 1ns / 1ps
package oaht_pkg;

  localparam int KEY_W       = 64;
  localparam int VAL_W       = 32;
  localparam int SIZE_W      = 11;
  localparam int ACT_W       = 2;
  localparam int ST_W        = 3;
  localparam int COLL_W      = 32;
  localparam int D_W         = 16;
  localparam int CFG_IDX_W   = 2;
  localparam int MIN_SLOTS   = 3;
  localparam int DEF_MAX_SLOTS = 1024;
  localparam int DEF_TABLE_SIZE = 13;
  localparam int QUAD_STEP_MUL = 5;
  localparam int QUAD_SQ_MUL   = 3;
  localparam int IN_DATA_W   = 96;
  localparam int OUT_DATA_W  = 96;

  localparam logic [KEY_W-1:0] MIX_ADD  = 64'h9e3779b97f4a7c15;
  localparam logic [KEY_W-1:0] MIX_MUL1 = 64'hbf58476d1ce4e5b9;
  localparam logic [KEY_W-1:0] MIX_MUL2 = 64'h94d049bb133111eb;

  typedef enum logic [ACT_W-1:0] {
    ACT_INSERT = 2'd0,
    ACT_SEARCH = 2'd1,
    ACT_REMOVE = 2'd2
  } action_t;

  typedef enum logic [1:0] {
    MARK_EMPTY = 2'd0,
    MARK_LIVE  = 2'd1,
    MARK_TOMB  = 2'd2
  } mark_t;

  typedef enum logic [ST_W-1:0] {
    ST_INSERTED  = 3'd0,
    ST_DUPLICATE = 3'd1,
    ST_FOUND     = 3'd2,
    ST_NOT_FOUND = 3'd3,
    ST_REMOVED   = 3'd4,
    ST_FULL      = 3'd5
  } status_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_TABLE_SIZE  = 2'd0,
    CFG_PROBE_MODE  = 2'd1,
    CFG_HASH_SELECT = 2'd2
  } cfg_idx_t;

  typedef enum logic [1:0] {
    WR_NONE   = 2'd0,
    WR_CLEAR  = 2'd1,
    WR_INSERT = 2'd2,
    WR_TOMB   = 2'd3
  } wr_kind_t;

  typedef enum logic [3:0] {
    S_CLEAR, S_IDLE, S_MUL1_0, S_MUL1_1, S_MUL1_2, S_MIXN,
    S_MUL2_0, S_MUL2_1, S_MUL2_2, S_HASH, S_SWAIT, S_PSTART,
    S_PWAIT, S_EVAL, S_INS_END, S_FIN
  } state_t;

  typedef struct packed {
    logic [VAL_W-1:0] value;
    logic [KEY_W-1:0] key;
    mark_t            mark;
  } slot_t;

  localparam int SLOT_W = $bits(slot_t);

  typedef struct packed {
    logic [SIZE_W-1:0] table_size;
    logic              probe_mode;
    logic              hash_select;
  } cfg_t;

  typedef struct packed {
    logic     load;
    logic     mul;
    logic [1:0] mul_ph;
    logic     mul_c2;
    logic     mix_next;
    logic     set_hash;
    logic     mod_start;
    logic     mod_sum;
    logic     set_step;
    logic     rd;
    logic     probe_inc;
    logic     note_tomb;
    logic     coll_inc;
    logic     advance;
    wr_kind_t wr;
    logic     live_inc;
    logic     live_dec;
    logic     set_res;
    status_t  res;
    logic     res_data;
    logic     out_load;
    logic     clr_step;
  } cmd_t;

  typedef struct packed {
    logic [ACT_W-1:0] act;
    logic  mod_done;
    mark_t mark;
    logic  key_eq;
    logic  last;
    logic  have_tomb;
    logic  clr_last;
    logic  out_busy;
  } sts_t;

endpackage

// ----- rtl/core/open_address_hash_table.sv -----
// Top level of the open-addressed hash table: configuration registers and
// the controller/datapath pair. Depends on oaht_pkg, oaht_ctrl, oaht_dp.
//
//  Channel  Direction  Handshake            Contents
//  in_      slave      in_tvalid/in_tready  tdata key, data_in; tuser action
//  out_     master     out_tvalid/out_tready tdata status .. collision_count
//  cfg_     slave      cfg_valid/cfg_ready  cfg_index register, cfg_data value
//
// Requests are served one at a time: in_tready is high only while idle. An
// insert, search or remove runs the key mixer, then the serial remainder unit
// (one bit per cycle over 64 bits) for the probe step and again for each slot
// probed; an unknown action goes straight to the result. After reset every
// slot of the store is cleared with in_tready low; cfg writes are taken at any
// time. A finished word waits in the output register while the next is
// accepted.
`timescale 1ns / 1ps
module open_address_hash_table
  import oaht_pkg::*;
#(
  parameter int MAX_SLOTS = DEF_MAX_SLOTS
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_tvalid,
  output logic                  in_tready,
  // [63:0] key, [95:64] data_in
  input  logic [IN_DATA_W-1:0]  in_tdata,
  // [1:0] action
  input  logic [ACT_W-1:0]      in_tuser,
  output logic                  out_tvalid,
  input  logic                  out_tready,
  // [2:0] status, [34:3] data_out, [45:35] probes, [56:46] entry_count,
  // [88:57] collision_count, [95:89] zero
  output logic [OUT_DATA_W-1:0] out_tdata,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [SIZE_W-1:0]     cfg_data
);

  cfg_t cfg_r;
  cmd_t cmd;
  sts_t sts;

  assign cfg_ready = 1'b1;

  // Configuration register writes.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.table_size  <= SIZE_W'(DEF_TABLE_SIZE);
      cfg_r.probe_mode  <= 1'b0;
      cfg_r.hash_select <= 1'b1;
    end else if (cfg_valid) begin
      case (cfg_index)
        CFG_TABLE_SIZE:  cfg_r.table_size  <= cfg_data;
        CFG_PROBE_MODE:  cfg_r.probe_mode  <= cfg_data[0];
        CFG_HASH_SELECT: cfg_r.hash_select <= cfg_data[0];
        default: ;
      endcase
    end
  end

  oaht_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .cmd       (cmd),
    .sts       (sts)
  );

  oaht_dp #(
    .MAX_SLOTS (MAX_SLOTS)
  ) u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg        (cfg_r),
    .cmd        (cmd),
    .sts        (sts),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

endmodule

// ----- rtl/core/oaht_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`timescale 1ns / 1ps
module oaht_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  // Write port and registered read port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem_r[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

// ----- rtl/core/oaht_mod.sv -----
// Bit-serial remainder unit: 64-bit dividend by an 11-bit divisor, one bit
// per cycle. Depends on oaht_pkg.
`timescale 1ns / 1ps
module oaht_mod
  import oaht_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  input  logic [KEY_W-1:0]  dividend,
  input  logic [SIZE_W-1:0] divisor,
  output logic              done,
  output logic [SIZE_W-1:0] rem
);

  localparam int CNT_W = $clog2(KEY_W + 1);

  logic [CNT_W-1:0]  cnt_r, cnt_nxt;
  logic              busy_r, busy_nxt;
  logic              done_r, done_nxt;
  logic [KEY_W-1:0]  dvd_r, dvd_nxt;
  logic [SIZE_W-1:0] div_r, div_nxt;
  logic [SIZE_W-1:0] rem_r, rem_nxt;
  logic [SIZE_W:0]   trial;

  // One restoring step per cycle; the partial remainder stays below the divisor.
  always_comb begin
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    dvd_nxt  = dvd_r;
    div_nxt  = div_r;
    rem_nxt  = rem_r;
    trial    = {rem_r, dvd_r[KEY_W-1]};
    if (start) begin
      cnt_nxt  = CNT_W'(KEY_W);
      busy_nxt = 1'b1;
      dvd_nxt  = dividend;
      div_nxt  = divisor;
      rem_nxt  = '0;
    end else if (busy_r) begin
      dvd_nxt = {dvd_r[KEY_W-2:0], 1'b0};
      if (trial >= {1'b0, div_r}) begin
        rem_nxt = SIZE_W'(trial - {1'b0, div_r});
      end else begin
        rem_nxt = SIZE_W'(trial);
      end
      cnt_nxt = cnt_r - CNT_W'(1);
      if (cnt_r == CNT_W'(1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r  <= '0;
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      cnt_r  <= cnt_nxt;
      busy_r <= busy_nxt;
      done_r <= done_nxt;
    end
    dvd_r <= dvd_nxt;
    div_r <= div_nxt;
    rem_r <= rem_nxt;
  end

  assign done = done_r;
  assign rem  = rem_r;

endmodule

// ----- rtl/core/oaht_dp.sv -----
// Datapath of the hash table: request registers, key mixer, probe sequence,
// slot store, counters and the output register. Depends on oaht_pkg,
// oaht_mod, oaht_ram and assert_macros.svh.
`timescale 1ns / 1ps
`include "assert_macros.svh"
module oaht_dp
  import oaht_pkg::*;
#(
  parameter int MAX_SLOTS = DEF_MAX_SLOTS
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  cfg_t                  cfg,
  input  cmd_t                  cmd,
  output sts_t                  sts,
  input  logic [IN_DATA_W-1:0]  in_tdata,
  input  logic [ACT_W-1:0]      in_tuser,
  output logic                  out_tvalid,
  input  logic                  out_tready,
  output logic [OUT_DATA_W-1:0] out_tdata
);

  localparam int AW = $clog2(MAX_SLOTS);

  logic [KEY_W-1:0]  key_r, sum_r, m_r, acc_r;
  logic [VAL_W-1:0]  data_r, dout_r;
  logic [ACT_W-1:0]  act_r;
  logic [D_W-1:0]    d_r;
  logic [SIZE_W-1:0] probes_r, live_r;
  logic [COLL_W-1:0] coll_r;
  logic              have_tomb_r;
  logic [AW-1:0]     tomb_r, idx_r, clr_r;
  status_t           res_r;

  logic              out_valid_r;
  status_t           o_status_r;
  logic [VAL_W-1:0]  o_dout_r;
  logic [SIZE_W-1:0] o_probes_r, o_live_r;
  logic [COLL_W-1:0] o_coll_r;

  logic [SIZE_W-1:0] n, n_m1;
  logic [KEY_W-1:0]  mix_x, mod_dvd;
  logic [SIZE_W-1:0] mod_div, rem;
  logic              mod_done;
  logic [31:0]       mul_a, mul_b;
  logic [63:0]       prod;
  logic [KEY_W-1:0]  mul_c;
  logic [D_W-1:0]    s_ext;
  logic              ram_we;
  logic [AW-1:0]     ram_waddr;
  slot_t             wslot, rd_slot;
  logic [SLOT_W-1:0] ram_rdata;

  // Effective table size, clamped to the supported range.
  always_comb begin
    if (cfg.table_size < SIZE_W'(MIN_SLOTS)) begin
      n = SIZE_W'(MIN_SLOTS);
    end else if (32'(cfg.table_size) > MAX_SLOTS) begin
      n = SIZE_W'(MAX_SLOTS);
    end else begin
      n = cfg.table_size;
    end
  end
  assign n_m1 = n - SIZE_W'(1);

  // Shared remainder unit: step from key mod (n-1), slot from sum mod n.
  assign mod_dvd = cmd.mod_sum ? sum_r : key_r;
  assign mod_div = cmd.mod_sum ? n : n_m1;

  oaht_mod u_mod (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (cmd.mod_start),
    .dividend (mod_dvd),
    .divisor  (mod_div),
    .done     (mod_done),
    .rem      (rem)
  );

  // One 32x32 partial product per cycle of the 64-bit mixer multiply.
  assign mix_x = in_tdata[KEY_W-1:0] + MIX_ADD;
  assign mul_c = cmd.mul_c2 ? MIX_MUL2 : MIX_MUL1;
  assign mul_a = (cmd.mul_ph == 2'd1) ? m_r[63:32] : m_r[31:0];
  assign mul_b = (cmd.mul_ph == 2'd2) ? mul_c[63:32] : mul_c[31:0];
  assign prod  = mul_a * mul_b;

  assign s_ext = D_W'(rem) + D_W'(1);

  // Slot store write selection.
  always_comb begin
    wslot     = '0;
    ram_we    = 1'b1;
    ram_waddr = idx_r;
    unique case (cmd.wr)
      WR_NONE: begin
        ram_we = 1'b0;
      end
      WR_CLEAR: begin
        ram_waddr  = clr_r;
        wslot.mark = MARK_EMPTY;
      end
      WR_INSERT: begin
        ram_waddr   = have_tomb_r ? tomb_r : idx_r;
        wslot.mark  = MARK_LIVE;
        wslot.key   = key_r;
        wslot.value = data_r;
      end
      WR_TOMB: begin
        wslot.mark  = MARK_TOMB;
        wslot.key   = rd_slot.key;
        wslot.value = rd_slot.value;
      end
    endcase
  end

  oaht_ram #(
    .WIDTH (SLOT_W),
    .DEPTH (MAX_SLOTS)
  ) u_slots (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (wslot),
    .re    (cmd.rd),
    .raddr (AW'(rem)),
    .rdata (ram_rdata)
  );
  assign rd_slot = slot_t'(ram_rdata);

  // Request, probe and hash registers.
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      key_r  <= in_tdata[KEY_W-1:0];
      data_r <= in_tdata[KEY_W +: VAL_W];
      act_r  <= in_tuser;
      m_r    <= mix_x ^ (mix_x >> 30);
    end else if (cmd.mix_next) begin
      m_r <= acc_r ^ (acc_r >> 27);
    end
    if (cmd.mul) begin
      if (cmd.mul_ph == 2'd0) begin
        acc_r <= prod;
      end else begin
        acc_r <= {acc_r[63:32] + prod[31:0], acc_r[31:0]};
      end
    end
    if (cmd.set_hash) begin
      sum_r <= cfg.hash_select ? key_r : (acc_r ^ (acc_r >> 31));
    end else if (cmd.advance) begin
      sum_r <= sum_r + KEY_W'(d_r);
    end
    if (cmd.set_step) begin
      d_r <= cfg.probe_mode ? (s_ext * D_W'(QUAD_STEP_MUL) + D_W'(QUAD_SQ_MUL)) : s_ext;
    end else if (cmd.advance && cfg.probe_mode) begin
      d_r <= d_r + D_W'(2 * QUAD_SQ_MUL);
    end
    if (cmd.rd) begin
      idx_r <= AW'(rem);
    end
    if (cmd.note_tomb) begin
      tomb_r <= idx_r;
    end
    if (cmd.load) begin
      res_r  <= ST_NOT_FOUND;
      dout_r <= '0;
    end else if (cmd.set_res) begin
      res_r <= cmd.res;
      if (cmd.res_data) begin
        dout_r <= rd_slot.value;
      end
    end
    if (cmd.out_load) begin
      o_status_r <= res_r;
      o_dout_r   <= dout_r;
      o_probes_r <= probes_r;
      o_live_r   <= live_r;
      o_coll_r   <= coll_r;
    end
  end

  // Control counters and flags.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      probes_r    <= '0;
      live_r      <= '0;
      coll_r      <= '0;
      have_tomb_r <= 1'b0;
      clr_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cmd.load) begin
        probes_r    <= '0;
        have_tomb_r <= 1'b0;
      end else begin
        if (cmd.probe_inc) begin
          probes_r <= probes_r + SIZE_W'(1);
        end
        if (cmd.note_tomb) begin
          have_tomb_r <= 1'b1;
        end
      end
      if (cmd.live_inc) begin
        live_r <= live_r + SIZE_W'(1);
      end else if (cmd.live_dec && live_r != '0) begin
        live_r <= live_r - SIZE_W'(1);
      end
      if (cmd.coll_inc && coll_r != '1) begin
        coll_r <= coll_r + COLL_W'(1);
      end
      if (cmd.clr_step) begin
        clr_r <= clr_r + AW'(1);
      end
      if (cmd.out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Status toward the controller.
  always_comb begin
    sts.act       = act_r;
    sts.mod_done  = mod_done;
    sts.mark      = rd_slot.mark;
    sts.key_eq    = (rd_slot.key == key_r);
    sts.last      = (probes_r == n_m1);
    sts.have_tomb = have_tomb_r;
    sts.clr_last  = (clr_r == AW'(MAX_SLOTS - 1));
    sts.out_busy  = out_valid_r & ~out_tready;
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {7'd0, o_coll_r, o_live_r, o_probes_r, o_dout_r, o_status_r};

  `ASSERT_ALWAYS(a_live_bound, clk, rst_n, 32'(live_r) <= MAX_SLOTS)
  `ASSERT_IMP(a_probe_bound, clk, rst_n, cmd.probe_inc, probes_r < n)
  `ASSERT_IMP(a_slot_in_range, clk, rst_n, cmd.rd, rem < n)

endmodule

// ----- rtl/core/oaht_ctrl.sv -----
// Controller of the hash table: sequences the reset sweep, hashing, the probe walk,
// updates and the result hand-off by commands to the datapath. Depends on oaht_pkg.
`timescale 1ns / 1ps
module oaht_ctrl
  import oaht_pkg::*;
(
  input  logic clk,
  input  logic rst_n,
  input  logic in_tvalid,
  output logic in_tready,
  output cmd_t cmd,
  input  sts_t sts
);

  state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_CLEAR;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Next state and commands.
  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_tready = 1'b0;
    unique case (state_r)
      S_CLEAR: begin
        cmd.wr       = WR_CLEAR;
        cmd.clr_step = 1'b1;
        if (sts.clr_last) begin
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        in_tready = 1'b1;
        if (in_tvalid) begin
          cmd.load  = 1'b1;
          state_nxt = S_MUL1_0;
        end
      end
      S_MUL1_0: begin
        case (sts.act)
          ACT_INSERT, ACT_SEARCH, ACT_REMOVE: begin
            cmd.mul   = 1'b1;
            state_nxt = S_MUL1_1;
          end
          default: state_nxt = S_FIN;
        endcase
      end
      S_MUL1_1: begin
        cmd.mul    = 1'b1;
        cmd.mul_ph = 2'd1;
        state_nxt  = S_MUL1_2;
      end
      S_MUL1_2: begin
        cmd.mul    = 1'b1;
        cmd.mul_ph = 2'd2;
        state_nxt  = S_MIXN;
      end
      S_MIXN: begin
        cmd.mix_next = 1'b1;
        state_nxt    = S_MUL2_0;
      end
      S_MUL2_0: begin
        cmd.mul    = 1'b1;
        cmd.mul_c2 = 1'b1;
        state_nxt  = S_MUL2_1;
      end
      S_MUL2_1: begin
        cmd.mul    = 1'b1;
        cmd.mul_c2 = 1'b1;
        cmd.mul_ph = 2'd1;
        state_nxt  = S_MUL2_2;
      end
      S_MUL2_2: begin
        cmd.mul    = 1'b1;
        cmd.mul_c2 = 1'b1;
        cmd.mul_ph = 2'd2;
        state_nxt  = S_HASH;
      end
      S_HASH: begin
        cmd.set_hash  = 1'b1;
        cmd.mod_start = 1'b1;
        state_nxt     = S_SWAIT;
      end
      S_SWAIT: begin
        if (sts.mod_done) begin
          cmd.set_step = 1'b1;
          state_nxt    = S_PSTART;
        end
      end
      S_PSTART: begin
        cmd.mod_start = 1'b1;
        cmd.mod_sum   = 1'b1;
        state_nxt     = S_PWAIT;
      end
      S_PWAIT: begin
        cmd.mod_sum = 1'b1;
        if (sts.mod_done) begin
          cmd.rd    = 1'b1;
          state_nxt = S_EVAL;
        end
      end
      S_EVAL: begin
        cmd.probe_inc = 1'b1;
        if (sts.act == ACT_INSERT) begin
          priority if (sts.mark == MARK_EMPTY) begin
            cmd.wr       = WR_INSERT;
            cmd.live_inc = 1'b1;
            cmd.set_res  = 1'b1;
            cmd.res      = ST_INSERTED;
            state_nxt    = S_FIN;
          end else if (sts.mark == MARK_LIVE && sts.key_eq) begin
            cmd.set_res = 1'b1;
            cmd.res     = ST_DUPLICATE;
            state_nxt   = S_FIN;
          end else begin
            // Occupied by another key counts a collision; the first tombstone is remembered.
            if (sts.mark == MARK_LIVE) begin
              cmd.coll_inc = 1'b1;
            end else if (!sts.have_tomb) begin
              cmd.note_tomb = 1'b1;
            end
            if (sts.last) begin
              state_nxt = S_INS_END;
            end else begin
              cmd.advance = 1'b1;
              state_nxt   = S_PSTART;
            end
          end
        end else begin
          priority if (sts.mark == MARK_EMPTY) begin
            state_nxt = S_FIN;
          end else if (sts.mark == MARK_LIVE && sts.key_eq) begin
            cmd.set_res = 1'b1;
            if (sts.act == ACT_SEARCH) begin
              cmd.res      = ST_FOUND;
              cmd.res_data = 1'b1;
            end else begin
              cmd.res      = ST_REMOVED;
              cmd.wr       = WR_TOMB;
              cmd.live_dec = 1'b1;
            end
            state_nxt = S_FIN;
          end else if (sts.last) begin
            state_nxt = S_FIN;
          end else begin
            cmd.advance = 1'b1;
            state_nxt   = S_PSTART;
          end
        end
      end
      S_INS_END: begin
        // Walk found no empty slot: reuse the first tombstone or report full.
        cmd.set_res = 1'b1;
        if (sts.have_tomb) begin
          cmd.wr       = WR_INSERT;
          cmd.live_inc = 1'b1;
          cmd.res      = ST_INSERTED;
        end else begin
          cmd.res = ST_FULL;
        end
        state_nxt = S_FIN;
      end
      S_FIN: begin
        if (!sts.out_busy) begin
          cmd.out_load = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

endmodule

// ----- tb/sv/open_address_hash_table_tb.sv -----
// Self-checking testbench for the open-addressed hash table: a scoreboard class
// predicts each result word from the accepted requests. Depends on oaht_pkg and
// open_address_hash_table.
`timescale 1ns / 1ps
module open_address_hash_table_tb;
  import oaht_pkg::*;

  localparam int SLOTS = DEF_MAX_SLOTS;
  localparam int STALL_LIMIT = 1000000;

  typedef struct packed {
    status_t     status;
    logic [31:0] data_out;
    logic [10:0] probes;
    logic [10:0] entry_count;
    logic [31:0] collision_count;
  } answer_t;

  // Predicts the table's answers and compares them with the result words.
  class table_scoreboard;
    mark_t       mark_q[SLOTS];
    logic [63:0] key_q[SLOTS];
    logic [31:0] value_q[SLOTS];
    int unsigned live;
    int unsigned collisions;
    logic [10:0] size_reg;
    bit          probe_quad;
    bit          raw_hash;
    answer_t     answers[$];
    int          errors;

    function void clear_table();
      for (int j = 0; j < SLOTS; j++) mark_q[j] = MARK_EMPTY;
      live = 0;
      collisions = 0;
      size_reg = 11'(DEF_TABLE_SIZE);
      probe_quad = 0;
      raw_hash = 1;
      errors = 0;
    endfunction

    function void write_reg(cfg_idx_t idx, logic [10:0] value);
      case (idx)
        CFG_TABLE_SIZE:  size_reg = value;
        CFG_PROBE_MODE:  probe_quad = value[0];
        CFG_HASH_SELECT: raw_hash = value[0];
        default: ;
      endcase
    endfunction

    function logic [63:0] splitmix(logic [63:0] x);
      x = x + MIX_ADD;
      x = (x ^ (x >> 30)) * MIX_MUL1;
      x = (x ^ (x >> 27)) * MIX_MUL2;
      return x ^ (x >> 31);
    endfunction

    function int unsigned slot_at(logic [63:0] h, logic [63:0] s, logic [63:0] i,
                                  int unsigned n);
      logic [63:0] sum;
      if (!probe_quad) sum = h + i * s;
      else sum = h + 64'd5 * i * s + 64'd3 * i * i;
      return int'(sum % 64'(n));
    endfunction

    // Runs one request against the model table and queues its answer.
    function void note_request(logic [1:0] act, logic [63:0] key, logic [31:0] din);
      int unsigned n, idx, tomb;
      logic [63:0] h, s;
      bit have_tomb, done;
      answer_t a;
      n = size_reg;
      if (n < 3) n = 3;
      if (n > SLOTS) n = SLOTS;
      h = raw_hash ? key : splitmix(key);
      s = 64'd1 + key % 64'(n - 1);
      a = '0;
      a.status = ST_NOT_FOUND;
      have_tomb = 0;
      done = 0;
      tomb = 0;
      if (act == ACT_INSERT) begin
        a.status = ST_FULL;
        for (int unsigned i = 0; i < n && !done; i++) begin
          idx = slot_at(h, s, i, n);
          a.probes++;
          if (mark_q[idx] == MARK_EMPTY) begin
            if (!have_tomb) tomb = idx;
            have_tomb = 1;
            done = 1;
          end else if (mark_q[idx] == MARK_LIVE) begin
            if (key_q[idx] == key) begin
              a.status = ST_DUPLICATE;
              done = 1;
              have_tomb = 0;
            end else if (collisions != 32'hFFFF_FFFF) begin
              collisions++;
            end
          end else if (!have_tomb) begin
            have_tomb = 1;
            tomb = idx;
          end
        end
        if (have_tomb) begin
          mark_q[tomb] = MARK_LIVE;
          key_q[tomb] = key;
          value_q[tomb] = din;
          live++;
          a.status = ST_INSERTED;
        end
      end else if (act == ACT_SEARCH || act == ACT_REMOVE) begin
        for (int unsigned i = 0; i < n; i++) begin
          idx = slot_at(h, s, i, n);
          a.probes++;
          if (mark_q[idx] == MARK_EMPTY) break;
          if (mark_q[idx] == MARK_LIVE && key_q[idx] == key) begin
            if (act == ACT_SEARCH) begin
              a.status = ST_FOUND;
              a.data_out = value_q[idx];
            end else begin
              mark_q[idx] = MARK_TOMB;
              if (live != 0) live--;
              a.status = ST_REMOVED;
            end
            break;
          end
        end
      end
      a.entry_count = 11'(live);
      a.collision_count = collisions;
      answers.insert(answers.size(), a);
    endfunction

    // Compares one result word with the oldest predicted answer.
    function void check_result(logic [OUT_DATA_W-1:0] word);
      answer_t a;
      if (answers.size() == 0) begin
        $error("result word with no request waiting: %h", word);
        errors++;
        return;
      end
      a = answers.pop_front();
      if (word[2:0] !== a.status) begin
        $error("status: expected %0d, got %0d", a.status, word[2:0]);
        errors++;
      end
      if (word[34:3] !== a.data_out) begin
        $error("data_out: expected %h, got %h", a.data_out, word[34:3]);
        errors++;
      end
      if (word[45:35] !== a.probes) begin
        $error("probes: expected %0d, got %0d", a.probes, word[45:35]);
        errors++;
      end
      if (word[56:46] !== a.entry_count) begin
        $error("entry_count: expected %0d, got %0d", a.entry_count, word[56:46]);
        errors++;
      end
      if (word[88:57] !== a.collision_count) begin
        $error("collision_count: expected %0d, got %0d", a.collision_count,
               word[88:57]);
        errors++;
      end
    endfunction
  endclass

  logic                  clk;
  logic                  rst_n;
  logic                  in_tvalid;
  logic                  in_tready;
  logic [IN_DATA_W-1:0]  in_tdata;
  logic [ACT_W-1:0]      in_tuser;
  logic                  out_tvalid;
  logic                  out_tready;
  logic [OUT_DATA_W-1:0] out_tdata;
  logic                  cfg_valid;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [SIZE_W-1:0]     cfg_data;

  table_scoreboard sb;
  bit              quiet;
  int              stall_cycles;
  logic [63:0]     key_pool[16];

  open_address_hash_table uut (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata),
    .in_tuser(in_tuser),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  initial begin
    clk = 0;
    forever #4 clk = ~clk;
  end

  // Monitors: requests feed the predictor, result words are checked.
  always @(posedge clk) begin
    if (rst_n && in_tvalid && in_tready) sb.note_request(in_tuser, in_tdata[63:0],
                                                         in_tdata[95:64]);
    if (rst_n && out_tvalid && out_tready) sb.check_result(out_tdata);
  end

  // Watchdog on cycles with no word moving on any channel.
  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready) ||
        (cfg_valid && cfg_ready)) begin
      stall_cycles <= 0;
    end else if (stall_cycles >= STALL_LIMIT) begin
      $display("open_address_hash_table_tb: FAIL");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  // Result side stalls in random bursts until the quiet stretch.
  initial begin
    out_tready <= 0;
    forever begin
      @(posedge clk);
      if (!quiet && $urandom_range(0, 5) == 0) begin
        out_tready <= 0;
        repeat ($urandom_range(1, 5)) @(posedge clk);
      end else begin
        out_tready <= 1;
      end
    end
  end

  task automatic send_request(action_t act, logic [63:0] key, logic [31:0] din);
    if (!quiet && $urandom_range(0, 4) == 0) begin
      in_tvalid <= 0;
      repeat ($urandom_range(1, 5)) @(posedge clk);
    end
    in_tvalid <= 1;
    in_tuser <= act;
    in_tdata <= {din, key};
    do @(posedge clk); while (!in_tready);
  endtask

  task automatic send_raw(logic [1:0] act, logic [63:0] key, logic [31:0] din);
    send_request(action_t'(act), key, din);
  endtask

  // Registers change only with the block idle.
  task automatic write_reg(cfg_idx_t idx, logic [10:0] value);
    in_tvalid <= 0;
    while (sb.answers.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    cfg_valid <= 1;
    cfg_index <= idx;
    cfg_data <= value;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 0;
    sb.write_reg(idx, value);
  endtask

  task automatic run_phase(logic [10:0] size, bit quad, bit raw, int count);
    logic [63:0] key;
    int pick;
    write_reg(CFG_TABLE_SIZE, size);
    write_reg(CFG_PROBE_MODE, quad);
    write_reg(CFG_HASH_SELECT, raw);
    // A small pool of keys makes duplicates, hits and removals common.
    foreach (key_pool[j]) begin
      case ($urandom_range(0, 3))
        0: key_pool[j] = $urandom_range(0, 200);
        1: key_pool[j] = ~64'($urandom_range(0, 200));
        default: key_pool[j] = {$urandom, $urandom};
      endcase
    end
    for (int k = 0; k < count; k++) begin
      if ($urandom_range(0, 99) < 85) key = key_pool[$urandom_range(0, 15)];
      else key = {$urandom, $urandom};
      pick = $urandom_range(0, 99);
      if (pick < 45) send_raw(ACT_INSERT, key, $urandom);
      else if (pick < 75) send_raw(ACT_SEARCH, key, $urandom);
      else if (pick < 95) send_raw(ACT_REMOVE, key, $urandom);
      else send_raw(2'd3, key, $urandom);
    end
  endtask

  initial begin
    sb = new;
    sb.clear_table();
    quiet = 0;
    stall_cycles = 0;
    rst_n <= 0;
    in_tvalid <= 0;
    in_tdata <= '0;
    in_tuser <= '0;
    cfg_valid <= 0;
    cfg_index <= '0;
    cfg_data <= '0;
    repeat (2) @(posedge clk);
    rst_n <= 1;
    @(posedge clk);

    // Directed: a three-slot table filled, overflowed, and a tombstone reused.
    write_reg(CFG_TABLE_SIZE, 11'd3);
    send_request(ACT_SEARCH, 64'd0, 32'd0);
    send_request(ACT_INSERT, 64'd0, 32'h7FFF_FFFF);
    send_request(ACT_INSERT, 64'd1, 32'h8000_0000);
    send_request(ACT_INSERT, 64'd2, 32'hFFFF_FFFF);
    send_request(ACT_INSERT, 64'd3, 32'd5);
    send_request(ACT_SEARCH, 64'd2, 32'd0);
    send_request(ACT_REMOVE, 64'd1, 32'd0);
    send_request(ACT_SEARCH, 64'd1, 32'd0);
    send_request(ACT_INSERT, 64'd4, 32'h1234_5678);
    send_request(ACT_INSERT, 64'd0, 32'd9);
    send_raw(2'd3, 64'd0, 32'hFFFF_FFFF);
    send_request(ACT_REMOVE, 64'd0, 32'd0);
    send_request(ACT_REMOVE, 64'd0, 32'd0);
    send_request(ACT_INSERT, 64'hFFFF_FFFF_FFFF_FFFF, 32'h8000_0000);
    send_request(ACT_SEARCH, 64'hFFFF_FFFF_FFFF_FFFF, 32'd0);
    send_request(ACT_SEARCH, 64'hAAAA_5555_AAAA_5555, 32'd0);

    // Random phases over several settings, out-of-range sizes among them.
    run_phase(11'd13, 0, 1, 490);
    run_phase(11'd3, 1, 0, 100);
    run_phase(11'd1024, 0, 0, 80);
    run_phase(11'd0, 0, 1, 100);
    run_phase(11'd2047, 1, 1, 60);
    run_phase(11'd31, 1, 0, 400);
    run_phase(11'd7, 0, 0, 300);
    quiet = 1;
    run_phase(11'd61, 1, 1, 300);

    in_tvalid <= 0;
    while (sb.answers.size() != 0) @(posedge clk);
    repeat (50) @(posedge clk);
    if (sb.errors == 0) begin
      $display("open_address_hash_table_tb: PASS");
    end else begin
      $display("open_address_hash_table_tb: FAIL");
    end
    $finish;
  end

endmodule
